FILE: hw/rtl/pal2rgba_pkg.sv
// shared types and constants for the palette index to rgba converter
package pal2rgba_pkg;

	localparam int PAL_DEPTH   = 256;
	localparam int PAL_AW      = 8;
	localparam int COLOR_W     = 24;
	localparam int RGBA_W      = 32;
	localparam int FMT_W       = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 2;

	localparam logic [PAL_AW-1:0] KEY_INDEX = 8'hFF;
	localparam logic [7:0]        ALPHA_FULL = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DITHER = 1'b1;

	// input function codes
	localparam logic FUNC_WRITE   = 1'b0;
	localparam logic FUNC_CONVERT = 1'b1;

	typedef enum logic [1:0] {
		MODE_OPAQUE   = 2'd0,
		MODE_ALPHA    = 2'd1,
		MODE_GRADIENT = 2'd2,
		MODE_RGBA     = 2'd3
	} mode_t;

	// reported texture formats
	localparam logic [FMT_W-1:0] FMT_OPAQUE   = 3'd0;
	localparam logic [FMT_W-1:0] FMT_ALPHA    = 3'd1;
	localparam logic [FMT_W-1:0] FMT_GRADIENT = 3'd2;
	localparam logic [FMT_W-1:0] FMT_RGBA     = 3'd3;
	localparam logic [FMT_W-1:0] FMT_INVALID  = 3'd4;

	// pixel held in the first stage
	typedef struct packed {
		logic              advance;
		logic              last;
		logic [PAL_AW-1:0] index;
	} texel_ctrl_t;

	// widen one channel by or-ing in its top two bits
	function automatic logic [7:0] widen_channel(input logic [7:0] c);
		widen_channel = c | {6'd0, c[7:6]};
	endfunction

endpackage

FILE: hw/rtl/pal2rgba_ram.sv
// generic single write port ram with registered read
module pal2rgba_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/pal2rgba_texel.sv
// texel formation and per-texture format tracking
module pal2rgba_texel (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pal2rgba_pkg::mode_t                 mode,
	input  logic                                dither_enable,
	input  pal2rgba_pkg::texel_ctrl_t           ctrl,
	input  logic [pal2rgba_pkg::COLOR_W-1:0]    pal_color,
	input  logic [pal2rgba_pkg::COLOR_W-1:0]    key_color,
	output logic [pal2rgba_pkg::RGBA_W-1:0]     rgba,
	output logic [pal2rgba_pkg::FMT_W-1:0]      result_format
);

	logic       all_opaque_q;
	logic [1:0] count_q;
	logic [1:0] count_next;
	logic       is_key;
	logic [pal2rgba_pkg::COLOR_W-1:0] wide_color;

	assign is_key     = (ctrl.index == pal2rgba_pkg::KEY_INDEX);
	assign count_next = count_q + 2'd1;

	assign wide_color = {pal2rgba_pkg::widen_channel(pal_color[23:16]),
	                     pal2rgba_pkg::widen_channel(pal_color[15:8]),
	                     pal2rgba_pkg::widen_channel(pal_color[7:0])};

	// word formation per mode
	always_comb begin
		unique case (mode)
			pal2rgba_pkg::MODE_OPAQUE: begin
				rgba = {pal2rgba_pkg::ALPHA_FULL, dither_enable ? wide_color : pal_color};
			end
			pal2rgba_pkg::MODE_ALPHA: begin
				rgba = is_key ? '0 : {pal2rgba_pkg::ALPHA_FULL, pal_color};
			end
			pal2rgba_pkg::MODE_GRADIENT: begin
				rgba = {ctrl.index, key_color};
			end
			default: begin
				rgba = {ctrl.index, pal_color};
			end
		endcase
	end

	// format on the last pixel, zero otherwise
	always_comb begin
		result_format = pal2rgba_pkg::FMT_OPAQUE;
		if (ctrl.last) begin
			unique case (mode)
				pal2rgba_pkg::MODE_OPAQUE: begin
					result_format = (count_next != 2'd0) ? pal2rgba_pkg::FMT_INVALID
					                                     : pal2rgba_pkg::FMT_OPAQUE;
				end
				pal2rgba_pkg::MODE_ALPHA: begin
					result_format = (all_opaque_q && !is_key) ? pal2rgba_pkg::FMT_OPAQUE
					                                          : pal2rgba_pkg::FMT_ALPHA;
				end
				pal2rgba_pkg::MODE_GRADIENT: begin
					result_format = pal2rgba_pkg::FMT_GRADIENT;
				end
				default: begin
					result_format = pal2rgba_pkg::FMT_RGBA;
				end
			endcase
		end
	end

	// tracking moves on when the pixel leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_opaque_q <= 1'b1;
			count_q      <= 2'd0;
		end else if (ctrl.advance) begin
			if (ctrl.last) begin
				all_opaque_q <= 1'b1;
				count_q      <= 2'd0;
			end else begin
				count_q <= count_next;
				if (is_key) begin
					all_opaque_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/palette_index_to_rgba_top.sv
// top level of the palette index to rgba converter
// Palette index to RGBA converter. Palette-write transactions (func 0) load the
// 256 x 24-bit palette and produce no result; convert transactions (func 1) each
// produce one 32-bit texel, red in bits 7:0 and alpha in 31:24. One transaction
// is taken every clock while in_stall is low: the index reads the palette ram
// (registered read) into the first stage, the texel is formed there and lands in
// the output register, and an output stall backs up through the two stages
// before the input stalls. Palette entries must be written before they are read.
// The user must see that mode and dither_enable are written only while no
// transaction is in flight; the block itself does not enforce it. The format on
// the last pixel follows the mode in force when that pixel is converted.
module palette_index_to_rgba_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_we,
	input  logic [pal2rgba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pal2rgba_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   func,
	input  logic [pal2rgba_pkg::PAL_AW-1:0]        index,
	input  logic [pal2rgba_pkg::COLOR_W-1:0]       color,
	input  logic                                   last,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [pal2rgba_pkg::RGBA_W-1:0]        rgba,
	output logic                                   last_out,
	output logic [pal2rgba_pkg::FMT_W-1:0]         result_format
);

	pal2rgba_pkg::mode_t mode_q;
	logic                dither_q;

	logic                                 in_accept;
	logic                                 pal_we;
	logic                                 pix_accept;
	logic                                 valid_s1;
	logic                                 last_s1;
	logic [pal2rgba_pkg::PAL_AW-1:0]      index_s1;
	logic                                 advance_s1;
	logic [pal2rgba_pkg::COLOR_W-1:0]     pal_rdata;
	logic [pal2rgba_pkg::COLOR_W-1:0]     key_color_q;
	pal2rgba_pkg::texel_ctrl_t            ctrl_s1;
	logic [pal2rgba_pkg::RGBA_W-1:0]      rgba_s1;
	logic [pal2rgba_pkg::FMT_W-1:0]       fmt_s1;
	logic                                 out_valid_q;
	logic [pal2rgba_pkg::RGBA_W-1:0]      rgba_q;
	logic                                 last_q;
	logic [pal2rgba_pkg::FMT_W-1:0]       fmt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= pal2rgba_pkg::MODE_OPAQUE;
			dither_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pal2rgba_pkg::CFG_MODE:   mode_q   <= pal2rgba_pkg::mode_t'(cfg_data);
				pal2rgba_pkg::CFG_DITHER: dither_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake and stage control
	assign advance_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign in_accept  = in_valid && !in_stall;
	assign pal_we     = in_accept && (func == pal2rgba_pkg::FUNC_WRITE);
	assign pix_accept = in_accept && (func == pal2rgba_pkg::FUNC_CONVERT);

	// palette storage
	pal2rgba_ram #(
		.WIDTH (pal2rgba_pkg::COLOR_W),
		.DEPTH (pal2rgba_pkg::PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (index),
		.wdata (color),
		.re    (pix_accept),
		.raddr (index),
		.rdata (pal_rdata)
	);

	// copy of the key entry for gradient mode
	always_ff @(posedge clk) begin
		if (pal_we && (index == pal2rgba_pkg::KEY_INDEX)) begin
			key_color_q <= color;
		end
	end

	// first stage: pixel beside its palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			index_s1 <= index;
			last_s1  <= last;
		end
	end

	assign ctrl_s1 = '{advance: advance_s1, last: last_s1, index: index_s1};

	pal2rgba_texel u_texel (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.dither_enable (dither_q),
		.ctrl          (ctrl_s1),
		.pal_color     (pal_rdata),
		.key_color     (key_color_q),
		.rgba          (rgba_s1),
		.result_format (fmt_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			rgba_q <= rgba_s1;
			last_q <= last_s1;
			fmt_q  <= fmt_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign rgba          = rgba_q;
	assign last_out      = last_q;
	assign result_format = fmt_q;

	// the input only stalls behind a full first stage
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked first stage");

	// a format other than opaque only comes with the last pixel
	a_fmt_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (fmt_q != pal2rgba_pkg::FMT_OPAQUE) |-> last_q)
		else $error("texture format reported on a pixel that is not last");

	// a pixel leaving the first stage always produces a result next cycle
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> out_valid_q)
		else $error("pixel left first stage without reaching the output");

	// a palette write never occupies the first stage
	a_write_no_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pal_we && !valid_s1 |=> !valid_s1)
		else $error("palette write entered the first stage");

endmodule

FILE: sim/tb_palette_index_to_rgba_top.sv
// self-checking testbench for the palette index to rgba converter
`timescale 1ns / 1ps

module tb_palette_index_to_rgba_top;
	import pal2rgba_pkg::*;

	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 140;
	localparam int LONG_HOLD    = 60;
	localparam int SETTLE_TICKS = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;
	// per phase register settings, phase 0 in the low bits
	localparam logic [2*PHASES-1:0] PHASE_MODES  = 18'b10_11_00_01_11_10_01_00_00;
	localparam logic [PHASES-1:0]   PHASE_DITHER = 9'b0_1_1_1_0_1_0_1_0;

	typedef struct packed {
		logic               func;
		logic [PAL_AW-1:0]  index;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_item_t;

	typedef struct packed {
		logic [RGBA_W-1:0] rgba;
		logic              last;
		logic [FMT_W-1:0]  fmt;
	} texel_t;

	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  typed;
		pixel_item_t           item;
		texel_t                want;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  func;
	logic [PAL_AW-1:0]     index;
	logic [COLOR_W-1:0]    color;
	logic                  last;
	logic                  out_valid;
	logic                  out_stall;
	logic [RGBA_W-1:0]     rgba;
	logic                  last_out;
	logic [FMT_W-1:0]      result_format;

	// shadow of the block state used for prediction
	logic [COLOR_W-1:0] pal_shadow [PAL_DEPTH];
	logic               key_free  = 1'b1;
	logic [1:0]         pix_phase = 2'd0;
	mode_t              cur_mode  = MODE_OPAQUE;
	logic               cur_dither = 1'b0;

	texel_t            texel_q [$];
	step_row_t         directed_q [$];
	logic [PAL_AW-1:0] pal_written_q [$];
	bit                pal_written [PAL_DEPTH];
	int                tex_left = 0;
	bit                tex_quiet = 1'b0;
	bit                stall_burst_req = 1'b0;
	int                mismatches = 0;
	int                cycles = 0;

	palette_index_to_rgba_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .index(index), .color(color), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.rgba(rgba), .last_out(last_out), .result_format(result_format)
	);

	always #2 clk = ~clk;

	// expected texel for one accepted transaction, returns 0 for a palette write
	function automatic bit predict_texel(input pixel_item_t it, output texel_t t);
		logic [COLOR_W-1:0] p;
		logic [COLOR_W-1:0] c;
		t = '0;
		if (it.func == FUNC_WRITE) begin
			pal_shadow[it.index] = it.color;
			return 1'b0;
		end
		p = pal_shadow[it.index];
		if (it.index == KEY_INDEX) key_free = 1'b0;
		pix_phase = pix_phase + 2'd1;
		case (cur_mode)
			MODE_OPAQUE: begin
				// top two bits of each channel folded into its bottom two
				c = cur_dither ? (p | ((p >> 6) & 24'h030303)) : p;
				t.rgba = {ALPHA_FULL, c};
			end
			MODE_ALPHA: t.rgba = (it.index == KEY_INDEX) ? '0 : {ALPHA_FULL, p};
			MODE_GRADIENT: t.rgba = {it.index, pal_shadow[KEY_INDEX]};
			default: t.rgba = {it.index, p};
		endcase
		t.last = it.last;
		if (it.last) begin
			case (cur_mode)
				MODE_OPAQUE: t.fmt = (pix_phase != 2'd0) ? FMT_INVALID : FMT_OPAQUE;
				MODE_ALPHA: t.fmt = key_free ? FMT_OPAQUE : FMT_ALPHA;
				MODE_GRADIENT: t.fmt = FMT_GRADIENT;
				default: t.fmt = FMT_RGBA;
			endcase
			key_free  = 1'b1;
			pix_phase = 2'd0;
		end
		return 1'b1;
	endfunction

	// directed table entries
	function automatic void row_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '0;
		r.is_reg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		directed_q.push_back(r);
	endfunction

	function automatic void row_px(input logic f, input logic [PAL_AW-1:0] idx,
			input logic [COLOR_W-1:0] col, input logic lst);
		step_row_t r;
		r = '0;
		r.item = '{func: f, index: idx, color: col, last: lst};
		directed_q.push_back(r);
		if (f == FUNC_WRITE && !pal_written[idx]) begin
			pal_written[idx] = 1'b1;
			pal_written_q.push_back(idx);
		end
	endfunction

	function automatic void row_chk(input logic [PAL_AW-1:0] idx, input logic lst,
			input logic [RGBA_W-1:0] want_rgba, input logic [FMT_W-1:0] want_fmt);
		step_row_t r;
		r = '0;
		r.typed = 1'b1;
		r.item  = '{func: FUNC_CONVERT, index: idx, color: COLOR_W'($urandom), last: lst};
		r.want  = '{rgba: want_rgba, last: lst, fmt: want_fmt};
		directed_q.push_back(r);
	endfunction

	// random palette write, marked last at random
	function automatic pixel_item_t next_write();
		pixel_item_t it;
		it.func  = FUNC_WRITE;
		it.index = PAL_AW'($urandom);
		it.color = COLOR_W'($urandom);
		it.last  = 1'($urandom);
		if (!pal_written[it.index]) begin
			pal_written[it.index] = 1'b1;
			pal_written_q.push_back(it.index);
		end
		return it;
	endfunction

	// next pixel of the current texture, only written entries are looked up
	function automatic pixel_item_t next_pixel();
		pixel_item_t it;
		int len;
		it.func  = FUNC_CONVERT;
		it.color = COLOR_W'($urandom);
		if (tex_left == 0) begin
			len = 4 * $urandom_range(1, 4);
			if ($urandom_range(0, 2) == 0) len = $urandom_range(1, 13);
			tex_left  = len;
			tex_quiet = ($urandom_range(0, 4) == 0);
		end
		if (cur_mode != MODE_OPAQUE && $urandom_range(0, 9) == 0) it.index = KEY_INDEX;
		else it.index = pal_written_q[$urandom_range(0, pal_written_q.size() - 1)];
		tex_left = tex_left - 1;
		it.last  = (tex_left == 0);
		return it;
	endfunction

	// sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int k;
		if (tex_quiet) return 0;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one transaction, record its expectation once accepted
	task automatic issue(input pixel_item_t it, input logic typed, input texel_t want,
			input int gap);
		texel_t t;
		in_valid <= 1'b1;
		func     <= it.func;
		index    <= it.index;
		color    <= it.color;
		last     <= it.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (predict_texel(it, t)) texel_q.push_back(typed ? want : t);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for the pipe to empty
	task automatic settle();
		in_valid <= 1'b0;
		while (texel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODE) cur_mode = mode_t'(val);
		else if (idx == CFG_DITHER) cur_dither = val[0];
		@(posedge clk);
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// compare each accepted texel with the oldest expectation
	always @(posedge clk) begin
		texel_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (texel_q.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected texel: rgba %h last %b fmt %0d",
						rgba, last_out, result_format);
			end else begin
				e = texel_q.pop_front();
				if (rgba !== e.rgba || last_out !== e.last || result_format !== e.fmt) begin
					mismatches = mismatches + 1;
					if (mismatches <= MAX_REPORTS)
						$display("texel mismatch: exp rgba %h last %b fmt %0d, got rgba %h last %b fmt %0d",
							e.rgba, e.last, e.fmt, rgba, last_out, result_format);
				end
			end
		end
	end

	// receiver stall pattern, with a long hold on request
	initial begin : out_side
		int k;
		int run_left;
		logic run_stall;
		run_left  = 0;
		run_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_burst_req) begin
				stall_burst_req = 1'b0;
				run_left  = LONG_HOLD;
				run_stall = 1'b1;
			end
			if (run_left == 0) begin
				k = $urandom_range(0, 99);
				run_stall = (k < 25);
				if (k < 20) run_left = $urandom_range(1, 3);
				else if (k < 25) run_left = $urandom_range(10, 40);
				else if (k < 35) run_left = $urandom_range(20, 60);
				else run_left = $urandom_range(1, 4);
			end
			run_left  = run_left - 1;
			out_stall <= run_stall;
		end
	end

	initial begin : stimulus
		step_row_t r;
		pixel_item_t it;
		logic [CFG_DATA_W-1:0] val;
		logic [CFG_DATA_W-1:0] dval;
		int ph;
		int n;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		func      = FUNC_WRITE;
		index     = '0;
		color     = '0;
		last      = 1'b0;
		out_stall = 1'b0;

		// palette load, then every mode at reset and forced settings
		row_px(FUNC_WRITE, 8'd0, 24'h000000, 1'b0);
		row_px(FUNC_WRITE, KEY_INDEX, 24'hFFFFFF, 1'b0);
		// palette write marked last leaves tracking alone
		row_px(FUNC_WRITE, 8'd128, 24'hC0407F, 1'b1);
		row_px(FUNC_WRITE, 8'd1, 24'h123456, 1'b0);
		row_chk(8'd0, 1'b0, 32'hFF000000, FMT_OPAQUE);
		row_chk(KEY_INDEX, 1'b0, 32'hFFFFFFFF, FMT_OPAQUE);
		row_chk(8'd128, 1'b0, 32'hFFC0407F, FMT_OPAQUE);
		row_chk(8'd1, 1'b1, 32'hFF123456, FMT_OPAQUE);
		// single pixel texture breaks the count of four
		row_chk(8'd0, 1'b1, 32'hFF000000, FMT_INVALID);
		row_reg(CFG_DITHER, 2'b01);
		row_px(FUNC_CONVERT, 8'd128, 24'h5A5A5A, 1'b0);
		row_chk(KEY_INDEX, 1'b1, 32'hFFFFFFFF, FMT_INVALID);
		// alpha keyed: fallback to opaque, then key index seen
		row_reg(CFG_MODE, MODE_ALPHA);
		row_chk(8'd1, 1'b0, 32'hFF123456, FMT_OPAQUE);
		row_chk(8'd0, 1'b1, 32'hFF000000, FMT_OPAQUE);
		row_chk(KEY_INDEX, 1'b0, 32'h00000000, FMT_OPAQUE);
		row_chk(8'd1, 1'b1, 32'hFF123456, FMT_ALPHA);
		row_reg(CFG_MODE, MODE_GRADIENT);
		row_chk(8'd0, 1'b0, 32'h00FFFFFF, FMT_OPAQUE);
		row_chk(8'd128, 1'b1, 32'h80FFFFFF, FMT_GRADIENT);
		row_reg(CFG_MODE, MODE_RGBA);
		row_chk(KEY_INDEX, 1'b0, 32'hFFFFFFFF, FMT_OPAQUE);
		row_chk(8'd128, 1'b0, 32'h80C0407F, FMT_OPAQUE);
		// mode change mid texture, format follows the mode at the last pixel
		row_reg(CFG_MODE, MODE_OPAQUE);
		row_px(FUNC_CONVERT, 8'd1, 24'hFFFFFF, 1'b1);
		// upper data bit is dropped on the dither register
		row_reg(CFG_DITHER, 2'b10);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		while (directed_q.size() != 0) begin
			r = directed_q.pop_front();
			if (r.is_reg) begin
				settle();
				write_reg(r.reg_idx, r.reg_val);
			end else begin
				issue(r.item, r.typed, r.want, $urandom_range(0, 2));
			end
		end

		// random textures under each register setting
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			val  = PHASE_MODES[2*ph +: 2];
			dval = CFG_DATA_W'($urandom);
			dval[0] = PHASE_DITHER[ph];
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_MODE, val);
				write_reg(CFG_DITHER, dval);
			end else begin
				write_reg(CFG_DITHER, dval);
				write_reg(CFG_MODE, val);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 50) begin
					// receiver holds off while transactions keep coming
					stall_burst_req = 1'b1;
					repeat (24) issue(next_pixel(), 1'b0, '0, 0);
				end
				if (ph == 5 && n == 70) settle();
				if ($urandom_range(0, 99) < 15) it = next_write();
				else it = next_pixel();
				issue(it, 1'b0, '0, pick_gap());
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
